### rtl/smpa_pkg.sv
// Shared types and constants for the sequence max pool / argmax block.
// No dependencies; smpa_ctl, smpa_upd, the top level and smpa_chk import this package.
`default_nettype none
package smpa_pkg;

    localparam int MAX_FEATURES = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int ROW_W        = 32;
    localparam int COL_W        = 6;
    localparam int CNT_W        = 7;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 56;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    // register index taken from paddr[2]
    localparam logic REG_FEATURE_COUNT = 1'b0;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           last;
        logic                           row_end;
        logic                           first;
        logic [COL_W-1:0]               col;
        logic [ROW_W-1:0]               row;
    } t_elem;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] max_value;
        logic [ROW_W-1:0]               max_row;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage
`default_nettype wire

### rtl/smpa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Reads return the old contents when the same address is written that cycle.
`default_nettype none
module smpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### rtl/smpa_ctl.sv
// Front end: feature_count register on the APB port, column/row counters and
// sequence-start flag. Builds the per-beat element descriptor. Uses smpa_pkg.
`default_nettype none
module smpa_ctl
    import smpa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               i_accept,
    input  wire logic [IN_DATA_W-1:0] i_tdata,
    input  wire logic               i_tlast,
    output t_elem                   o_elem
);

    logic [CNT_W-1:0] r_feature_count;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_first;

    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] col_ext;
    logic             row_end;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FEATURE_COUNT)
                  ? {{(PDATA_W-CNT_W){1'b0}}, r_feature_count} : '0;

    always_comb begin
        if (r_feature_count == '0) begin
            cnt = CNT_W'(1);
        end else if (r_feature_count > CNT_W'(MAX_FEATURES)) begin
            cnt = CNT_W'(MAX_FEATURES);
        end else begin
            cnt = r_feature_count;
        end
        // clamp when the count shrank below the current column
        col_ext = ({1'b0, r_col} >= cnt) ? cnt - CNT_W'(1) : {1'b0, r_col};
        row_end = (col_ext + CNT_W'(1)) >= cnt;

        o_elem.sample  = i_tdata[SAMPLE_WIDTH-1:0];
        o_elem.last    = i_tlast;
        o_elem.row_end = row_end;
        o_elem.first   = r_first;
        o_elem.col     = col_ext[COL_W-1:0];
        o_elem.row     = r_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_count <= CNT_W'(1);
            r_col           <= '0;
            r_row           <= '0;
            r_first         <= 1'b1;
        end else begin
            if (psel && penable && pwrite && (paddr[2] == REG_FEATURE_COUNT)) begin
                r_feature_count <= pwdata[CNT_W-1:0];
            end
            if (i_accept) begin
                if (row_end) begin
                    r_col   <= '0;
                    r_row   <= r_row + ROW_W'(1);
                    r_first <= i_tlast;
                end else begin
                    r_col   <= col_ext[COL_W-1:0] + COL_W'(1);
                end
            end
        end
    end

endmodule
`default_nettype wire

### rtl/smpa_upd.sv
// Update stage: compares the beat with the stored column entry, writes it back
// and fills the output register. Forwards the previous write on a same-column
// hit. Uses smpa_pkg; drives the write port of the column RAM.
`default_nettype none
module smpa_upd
    import smpa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire t_elem                i_elem,
    output logic                      o_ready,
    input  wire logic [ENTRY_W-1:0]   i_rdata,
    output logic                      o_we,
    output logic [COL_W-1:0]          o_waddr,
    output logic [ENTRY_W-1:0]        o_wdata,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [OUT_DATA_W-1:0]     o_m_tdata,
    output logic                      o_m_tlast
);

    t_elem  r_s1;
    logic   r_s1_valid;
    logic   r_fwd_hit;
    t_entry r_fwd_data;

    t_entry stored;
    t_entry updated;
    logic   take;
    logic   fire;

    always_comb begin
        stored  = r_fwd_hit ? r_fwd_data : t_entry'(i_rdata);
        take    = r_s1.first || (r_s1.sample > stored.max_value);
        updated = take ? t_entry'{max_value: r_s1.sample, max_row: r_s1.row} : stored;
        fire    = r_s1_valid && (!o_m_tvalid || i_m_tready);
        o_ready = !r_s1_valid || fire;
        o_we    = fire;
        o_waddr = r_s1.col;
        o_wdata = updated;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            o_m_tvalid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (fire) begin
                r_s1_valid <= 1'b0;
            end
            if (fire && r_s1.last) begin
                o_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1       <= i_elem;
            // the RAM read this cycle misses a write to the same column
            r_fwd_hit  <= fire && (r_s1.col == i_elem.col);
            r_fwd_data <= updated;
        end
        if (fire && r_s1.last) begin
            o_m_tdata <= {2'b00, r_s1.col, updated.max_row, updated.max_value};
            o_m_tlast <= r_s1.row_end;
        end
    end

endmodule
`default_nettype wire

### rtl/sequence_max_pool_argmax_core.sv
// Top level of the sequence max pool / argmax block.
// Instantiates smpa_ctl, smpa_upd and smpa_ram; uses smpa_pkg.
//
//  Channel   Dir  Handshake             Payload
//  s (in)    in   i_s_tvalid/o_s_tready tdata[15:0] sample_value, tlast last_row
//  m (out)   out  o_m_tvalid/i_m_tready tdata[15:0] max_value, [47:16] max_row,
//                                       [53:48] feature_position; tlast last_of_sequence
//  cfg       in   psel/penable/pwrite   paddr 0: feature_count[6:0]
//
// One beat per cycle while the output is not stalled. The RAM read is registered on the
// accepting edge; compare and write back then load the output register on last_row.
// The column RAM has one read and one write port; back-to-back beats on the
// same column use a forwarding register. Reset sets feature_count to 1 and clears
// counters and handshake state; RAM contents stay undefined until each column is loaded.
// A stalled output holds the update stage, which then drops o_s_tready.
`default_nettype none
module sequence_max_pool_argmax_core
    import smpa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,   // [15:0] sample_value
    input  wire logic                  i_s_tlast,   // last_row
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,   // [15:0] max_value, [47:16] max_row,
                                                    // [53:48] feature_position, zero fill
    output logic                       o_m_tlast,   // last_of_sequence
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [PDATA_W-1:0]    pwdata,
    output logic      [PDATA_W-1:0]    prdata,
    output logic                       pready
);

    t_elem              elem;
    logic               accept;
    logic               we;
    logic [COL_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;

    assign accept = i_s_tvalid && o_s_tready;

    smpa_ctl u_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_accept (accept),
        .i_tdata  (i_s_tdata),
        .i_tlast  (i_s_tlast),
        .o_elem   (elem)
    );

    smpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_FEATURES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (accept),
        .i_raddr (elem.col),
        .o_rdata (rdata)
    );

    smpa_upd u_upd (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_elem     (elem),
        .o_ready    (o_s_tready),
        .i_rdata    (rdata),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire

### rtl/smpa_chk.sv
// Port-level checks for sequence_max_pool_argmax_core, bound to the top level.
// Uses smpa_pkg for widths.
`default_nettype none
module smpa_chk
    import smpa_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_s_tready,
    input wire logic                  o_m_tvalid,
    input wire logic                  i_m_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_tdata,
    input wire logic                  o_m_tlast
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast))
        else $error("result beat changed while stalled");

    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // an empty output register never backs up the input
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with free output register");

    // checks only that the fill bits above the column position stay zero
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[OUT_DATA_W-1:54] == '0))
        else $error("result padding not zero");

endmodule

bind sequence_max_pool_argmax_core smpa_chk u_chk (.*);
`default_nettype wire
